// ----- hdl/kpsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad scan and debounce package
// Shared constants, state codes and types for the 4x4 keypad scanner.
// ----------------------------------------------------------------------------
package kpsd_pkg;

   localparam int unsigned MatrixWidth = 16;
   localparam int unsigned KeyWidth    = 5;
   localparam int unsigned StateWidth  = 3;
   localparam int unsigned RspWidth    = 24;

   localparam logic [KeyWidth-1:0] KEY_NONE = 5'd16;

   localparam logic [StateWidth-1:0] ST_FREE       = 3'd0;
   localparam logic [StateWidth-1:0] ST_PREPRESS   = 3'd1;
   localparam logic [StateWidth-1:0] ST_PRESSED    = 3'd2;
   localparam logic [StateWidth-1:0] ST_PRERELEASE = 3'd3;
   localparam logic [StateWidth-1:0] ST_RELEASED   = 3'd4;

   typedef struct packed {
      logic [KeyWidth-1:0]   released_key;
      logic [KeyWidth-1:0]   pressed_key;
      logic [StateWidth-1:0] debounce_state;
      logic [KeyWidth-1:0]   scanned_key;
   } result_type;

endpackage : kpsd_pkg
`default_nettype wire

// ----- hdl/kpsd_scan_enc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad matrix encoder
// Finds the first active row and the first active column of a 4x4 snapshot
// independently and forms the key index, or the no-key code.
// ----------------------------------------------------------------------------
module kpsd_scan_enc (
   input  wire logic [kpsd_pkg::MatrixWidth-1:0] key_matrix,
   output logic      [kpsd_pkg::KeyWidth-1:0]    scanned_key
);

   logic [3:0] row_any;
   logic [3:0] col_any;
   logic [1:0] row_idx;
   logic [1:0] col_idx;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         row_any[i] = |key_matrix[i*4 +: 4];
         col_any[i] = key_matrix[i] | key_matrix[i+4] | key_matrix[i+8] | key_matrix[i+12];
      end
   end

   always_comb begin
      row_idx = 2'd0;
      col_idx = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (row_any[i]) begin
            row_idx = 2'(i);
         end
         if (col_any[i]) begin
            col_idx = 2'(i);
         end
      end
   end

   always_comb begin
      if ((|row_any) && (|col_any)) begin
         scanned_key = {1'b0, row_idx, col_idx};
      end else begin
         scanned_key = kpsd_pkg::KEY_NONE;
      end
   end

endmodule : kpsd_scan_enc
`default_nettype wire

// ----- hdl/keypad_scan_debounce.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad scan and debounce
// Scans a 4x4 key matrix snapshot per beat and debounces the key index.
// ----------------------------------------------------------------------------
// Each req beat carries one scan tick: a 16-bit snapshot of the key matrix,
// bit row*4+col set when that key is down. Each req beat yields exactly one
// rsp beat with the scanned key (16 for none), the debounce state after the
// tick, the held key and the most recently released key.
// The beat is captured in an input register, encoded and run through the
// debounce state machine combinationally, and written to the result register.
// rsp_tvalid rises once the result register holds the beat. Throughput is one
// beat per cycle while rsp_tready is high; the state update for a tick is made
// by the encoder and state machine between the two registers.
// When rsp_tready is low the result register holds, the input register still
// takes one more beat, and req_tready then drops until the result drains.
// Reset empties both registers and returns the machine to free with all key
// registers at zero.
// ----------------------------------------------------------------------------
module keypad_scan_debounce (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] key_matrix
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [4:0] scanned_key, [7:5] debounce_state,
                                         // [12:8] pressed_key_out,
                                         // [17:13] released_key_out, [23:18] zero
);

   logic                                   in_valid_ff, in_valid_in;
   logic [kpsd_pkg::MatrixWidth-1:0]       in_data_ff;
   logic                                   out_valid_ff, out_valid_in;
   kpsd_pkg::result_type                   out_data_ff, out_data_in;

   logic [kpsd_pkg::StateWidth-1:0]        state_ff, state_in;
   logic [kpsd_pkg::KeyWidth-1:0]          last_key_ff, last_key_in;
   logic [kpsd_pkg::KeyWidth-1:0]          held_key_ff, held_key_in;
   logic [kpsd_pkg::KeyWidth-1:0]          released_key_ff, released_key_in;

   logic [kpsd_pkg::KeyWidth-1:0]          scanned_key;
   logic                                   key_none;
   logic                                   advance;

   kpsd_scan_enc u_scan_enc (
      .key_matrix  (in_data_ff),
      .scanned_key (scanned_key)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign key_none   = (scanned_key == kpsd_pkg::KEY_NONE);

   always_comb begin
      state_in        = state_ff;
      held_key_in     = held_key_ff;
      released_key_in = released_key_ff;
      unique case (state_ff)
         kpsd_pkg::ST_PREPRESS: begin
            if (key_none) begin
               state_in = kpsd_pkg::ST_FREE;
            end else if (scanned_key == last_key_ff) begin
               held_key_in = scanned_key;
               state_in    = kpsd_pkg::ST_PRESSED;
            end
         end
         kpsd_pkg::ST_PRESSED: begin
            if (key_none) begin
               state_in        = kpsd_pkg::ST_PRERELEASE;
               released_key_in = held_key_ff;
            end else if (scanned_key != held_key_ff) begin
               state_in = kpsd_pkg::ST_PREPRESS;
            end
         end
         kpsd_pkg::ST_PRERELEASE: begin
            if (key_none) begin
               state_in = kpsd_pkg::ST_RELEASED;
            end else if (scanned_key == last_key_ff) begin
               held_key_in = scanned_key;
               state_in    = kpsd_pkg::ST_PRESSED;
            end
         end
         kpsd_pkg::ST_RELEASED: begin
            state_in = key_none ? kpsd_pkg::ST_FREE : kpsd_pkg::ST_PRERELEASE;
         end
         default: begin
            if (!key_none) begin
               state_in    = kpsd_pkg::ST_PREPRESS;
               held_key_in = scanned_key;
            end else begin
               state_in = kpsd_pkg::ST_FREE;
            end
         end
      endcase
      last_key_in = scanned_key;
   end

   always_comb begin
      out_data_in.scanned_key    = scanned_key;
      out_data_in.debounce_state = state_in;
      out_data_in.pressed_key    = held_key_in;
      out_data_in.released_key   = released_key_in;
   end

   assign in_valid_in  = req_tvalid || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff        <= kpsd_pkg::ST_FREE;
         last_key_ff     <= '0;
         held_key_ff     <= '0;
         released_key_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff        <= state_in;
            last_key_ff     <= last_key_in;
            held_key_ff     <= held_key_in;
            released_key_ff <= released_key_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};

   a_state_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_data_ff.debounce_state <= kpsd_pkg::ST_RELEASED))
      else $error("debounce state out of range");

   a_none_state : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.scanned_key == kpsd_pkg::KEY_NONE) |->
         (out_data_ff.debounce_state == kpsd_pkg::ST_FREE ||
          out_data_ff.debounce_state == kpsd_pkg::ST_PRERELEASE ||
          out_data_ff.debounce_state == kpsd_pkg::ST_RELEASED))
      else $error("no key seen but machine claims a key");

   a_pressed_match : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.debounce_state == kpsd_pkg::ST_PRESSED) |->
         (out_data_ff.pressed_key == out_data_ff.scanned_key))
      else $error("pressed state with held key different from scanned key");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule : keypad_scan_debounce
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad scan and debounce testbench
// Drives key matrix snapshots with random gaps and checks every result beat
// against a cycle-free model of the row and column encoder and the debounce
// state machine, under random back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   logic [15:0]          pending_matrices[$];
   kpsd_pkg::result_type expected_results[$];
   int unsigned mismatch_count = 0;
   int unsigned random_count = 0;

   logic        req_beat_taken = 1'b0;
   logic        rsp_beat_taken = 1'b0;
   int unsigned req_gap_left = 0;
   int unsigned req_quiet_left = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_quiet_left = 0;

   logic [kpsd_pkg::StateWidth-1:0] model_state = kpsd_pkg::ST_FREE;
   logic [kpsd_pkg::KeyWidth-1:0]   model_last = '0;
   logic [kpsd_pkg::KeyWidth-1:0]   model_held = '0;
   logic [kpsd_pkg::KeyWidth-1:0]   model_released = '0;

   keypad_scan_debounce i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] key_matrix
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [4:0] scanned_key, [7:5] debounce_state,
                                  // [12:8] pressed_key_out,
                                  // [17:13] released_key_out, [23:18] zero
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [kpsd_pkg::KeyWidth-1:0] encode_matrix(logic [15:0] matrix);
      int row;
      int col;
      row = 4;
      col = 4;
      for (int i = 3; i >= 0; i--) begin
         if (matrix[i*4 +: 4] != 4'h0) row = i;
         if ((matrix & (16'h1111 << i)) != 16'h0) col = i;
      end
      if (row == 4 || col == 4) return kpsd_pkg::KEY_NONE;
      return kpsd_pkg::KeyWidth'(row * 4 + col);
   endfunction

   function automatic kpsd_pkg::result_type debounce_tick(logic [15:0] matrix);
      logic [kpsd_pkg::KeyWidth-1:0] key;
      logic                          none;
      kpsd_pkg::result_type          res;
      key  = encode_matrix(matrix);
      none = (key == kpsd_pkg::KEY_NONE);
      case (model_state)
         kpsd_pkg::ST_PREPRESS: begin
            if (none) begin
               model_state = kpsd_pkg::ST_FREE;
            end else if (key == model_last) begin
               model_held  = key;
               model_state = kpsd_pkg::ST_PRESSED;
            end
         end
         kpsd_pkg::ST_PRESSED: begin
            if (none) begin
               model_state    = kpsd_pkg::ST_PRERELEASE;
               model_released = model_held;
            end else if (key != model_held) begin
               model_state = kpsd_pkg::ST_PREPRESS;
            end
         end
         kpsd_pkg::ST_PRERELEASE: begin
            if (none) begin
               model_state = kpsd_pkg::ST_RELEASED;
            end else if (key == model_last) begin
               model_held  = key;
               model_state = kpsd_pkg::ST_PRESSED;
            end
         end
         kpsd_pkg::ST_RELEASED: begin
            model_state = none ? kpsd_pkg::ST_FREE : kpsd_pkg::ST_PRERELEASE;
         end
         default: begin
            if (!none) begin
               model_state = kpsd_pkg::ST_PREPRESS;
               model_held  = key;
            end else begin
               model_state = kpsd_pkg::ST_FREE;
            end
         end
      endcase
      model_last = key;
      res.scanned_key    = key;
      res.debounce_state = model_state;
      res.pressed_key    = model_held;
      res.released_key   = model_released;
      return res;
   endfunction

   // Either side sometimes runs a stretch of beats with no idle cycles at all.
   function automatic int unsigned draw_wait(inout int unsigned quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic check_result(logic [23:0] beat);
      kpsd_pkg::result_type want;
      kpsd_pkg::result_type got;
      got = kpsd_pkg::result_type'(beat[17:0]);
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result beat %h", beat);
      end else begin
         want = expected_results.pop_front();
         compare_field("scanned_key", want.scanned_key, got.scanned_key);
         compare_field("debounce_state", want.debounce_state, got.debounce_state);
         compare_field("pressed_key_out", want.pressed_key, got.pressed_key);
         compare_field("released_key_out", want.released_key, got.released_key);
         compare_field("padding", 0, beat[23:18]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         model_state    = kpsd_pkg::ST_FREE;
         model_last     = '0;
         model_held     = '0;
         model_released = '0;
         req_beat_taken <= 1'b0;
         rsp_beat_taken <= 1'b0;
      end else begin
         req_beat_taken <= req_tvalid && req_tready;
         rsp_beat_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) expected_results.push_back(debounce_tick(req_tdata));
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_matrices.size() > 0) begin
            req_tdata    <= pending_matrices.pop_front();
            req_tvalid   <= 1'b1;
            req_gap_left  = draw_wait(req_quiet_left);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_beat_taken || !rsp_tready) begin
         if (rsp_beat_taken) rsp_stall_left = draw_wait(rsp_quiet_left);
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Extra keys are only added below and to the right of the chosen key, so
   // the encoder still picks the chosen key.
   function automatic logic [15:0] matrix_for_key(int unsigned key);
      logic [15:0] shadow;
      shadow = '0;
      for (int unsigned r = key / 4; r < 4; r++)
         for (int unsigned c = key % 4; c < 4; c++) shadow[r*4+c] = 1'b1;
      if ($urandom_range(0, 3) == 0)
         return (shadow & 16'($urandom_range(0, 65535))) | (16'd1 << key);
      return 16'd1 << key;
   endfunction

   task automatic push_press_run();
      int unsigned key;
      int unsigned hold;
      int unsigned gone;
      key  = $urandom_range(0, 15);
      hold = $urandom_range(1, 6);
      gone = $urandom_range(1, 4);
      for (int unsigned i = 0; i < hold; i++) begin
         if ($urandom_range(0, 5) != 0)
            pending_matrices.push_back(matrix_for_key(key));
         else if ($urandom_range(0, 1) == 0)
            pending_matrices.push_back(16'h0000);
         else
            pending_matrices.push_back(matrix_for_key($urandom_range(0, 15)));
      end
      for (int unsigned i = 0; i < gone; i++) begin
         if ($urandom_range(0, 5) == 0) pending_matrices.push_back(matrix_for_key(key));
         else pending_matrices.push_back(16'h0000);
      end
      random_count += hold + gone;
   endtask

   task automatic fill_random(int unsigned target);
      while (random_count < target) begin
         if ($urandom_range(0, 3) != 0) begin
            push_press_run();
         end else begin
            pending_matrices.push_back(16'($urandom_range(0, 65535)));
            random_count++;
         end
      end
   endtask

   task automatic wait_until_drained();
      while (pending_matrices.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Press, release and bounce paths through every state, then multi-key
      // snapshots where the row and column come from different keys.
      pending_matrices = '{16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
                           16'h0020, 16'h0080, 16'h0080, 16'h0400, 16'h0000,
                           16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'h8000,
                           16'h0000, 16'h0010, 16'h0000, 16'h0012, 16'h0012,
                           16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h8420};

      wait_until_drained();
      fill_random(450);
      wait_until_drained();
      fill_random(900);
      wait_until_drained();
      repeat (8) @(posedge clock);

      if (expected_results.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2400000;
      $display("tb: failure");
      $finish;
   end

endmodule : tb_top
